// ===== design/ist_pkg.sv =====
// Shared types and constants for the integer set table.
package ist_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_MEMBER  = 2'd2,
        OP_EXTRACT = 2'd3
    } t_op;

    // per-word update command broadcast to every cell
    typedef struct packed {
        logic shift_back;   // take the newer neighbor's entry (add)
        logic remove;       // take the older neighbor's entry if at or past the hit
        logic shift_front;  // take the older neighbor's entry (extract)
    } t_cell_ctl;

endpackage

// ===== design/ist_cell.sv =====
// One slot of the table: holds an entry, compares it and moves it to a neighbor.
module ist_cell
    import ist_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic                     i_slot_valid,
    input  logic signed [DATA_W-1:0] i_elem,
    input  logic signed [DATA_W-1:0] i_newer,
    input  logic signed [DATA_W-1:0] i_older,
    input  logic                     i_hit,
    output logic                     o_hit,
    output logic signed [DATA_W-1:0] o_entry
);

    logic signed [DATA_W-1:0] r_entry;

    // hit ripples from the newest slot toward the oldest
    assign o_hit   = i_hit | (i_slot_valid && (r_entry == i_elem));
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_back) begin
            r_entry <= i_newer;
        end else if (i_ctl.shift_front || (i_ctl.remove && o_hit)) begin
            r_entry <= i_older;
        end
    end

endmodule

// ===== design/integer_set_table.sv =====
// Integer set table: a chain of compare-and-shift cells holding distinct values, newest first.
// A set of up to CAPACITY distinct signed 32-bit values, newest first. Each word on the input
// is add, remove, member test or extract newest; each gives one result word with ok, the
// extracted value (zero unless an extract succeeded) and the count after the request. One
// word is taken per clock cycle: every cell compares its entry with the request in the same
// cycle, a hit flag ripples down the chain of cells, and all cells shift at the next edge.
// The result is registered; the input stalls only while a result is
// held back by a stalled output.
module integer_set_table
    import ist_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_op,
    input  logic signed [DATA_W-1:0] i_elem,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_ok,
    output logic signed [DATA_W-1:0] o_data_out,
    output logic [CNT_W-1:0]         o_count
);

    logic                     r_out_valid;
    logic                     r_ok;
    logic signed [DATA_W-1:0] r_data;
    logic [CNT_W-1:0]         r_count;

    logic                     n_ok;
    logic signed [DATA_W-1:0] n_data;
    logic [CNT_W-1:0]         n_count;

    logic                     w_accept;
    logic                     w_found;
    logic                     w_full;
    t_cell_ctl                w_ctl;

    logic                     w_hit   [0:CAPACITY];
    logic signed [DATA_W-1:0] w_entry [0:CAPACITY-1];

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_hit[0] = 1'b0;
    assign w_found  = w_hit[CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [DATA_W-1:0] w_newer;
            logic signed [DATA_W-1:0] w_older;

            if (g == 0) begin : g_first
                assign w_newer = i_elem;
            end else begin : g_mid
                assign w_newer = w_entry[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_older = w_entry[g];
            end else begin : g_inner
                assign w_older = w_entry[g+1];
            end

            ist_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_slot_valid (CNT_W'(g) < r_count),
                .i_elem       (i_elem),
                .i_newer      (w_newer),
                .i_older      (w_older),
                .i_hit        (w_hit[g]),
                .o_hit        (w_hit[g+1]),
                .o_entry      (w_entry[g])
            );
        end
    endgenerate

    always_comb begin
        w_ctl   = '0;
        n_ok    = 1'b0;
        n_data  = '0;
        n_count = r_count;
        case (t_op'(i_op))
            OP_ADD: begin
                if (!w_found && !w_full) begin
                    n_ok             = 1'b1;
                    n_count          = r_count + 1'b1;
                    w_ctl.shift_back = w_accept;
                end
            end
            OP_REMOVE: begin
                if (w_found) begin
                    n_ok         = 1'b1;
                    n_count      = r_count - 1'b1;
                    w_ctl.remove = w_accept;
                end
            end
            OP_MEMBER: begin
                n_ok = w_found;
            end
            OP_EXTRACT: begin
                if (r_count != '0) begin
                    n_ok              = 1'b1;
                    n_data            = w_entry[0];
                    n_count           = r_count - 1'b1;
                    w_ctl.shift_front = w_accept;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok   <= n_ok;
            r_data <= n_data;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_ok       = r_ok;
    assign o_data_out = r_data;
    assign o_count    = r_count;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op == OP_ADD && n_ok) |=> (r_count == $past(r_count) + 1'b1))
        else $error("successful add did not grow count");

    a_empty_extract: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op == OP_EXTRACT && r_count == '0) |=> (!o_ok && o_data_out == '0))
        else $error("extract from empty table reported data");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_data_out == '0))
        else $error("failed request carries data");
`endif

endmodule
